// ===== sv/ash_pkg.sv =====
// ----------------------------------------------------------------------------
// ash_pkg: shared types and constants for the antenna shadow flagger
// Item layouts, register map, controller state codes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ash_pkg;

  localparam int unsigned MAX_ANTENNAS_DEF = 64;

  localparam int unsigned ANT_IDX_W = 6;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned DIAM_W    = 18;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned TOL_W     = 19;

  // A pair this far apart or more in u or v can never pass the squared test.
  localparam int unsigned MAG_W = 21;
  // Threshold d_a + d_b - 2*tolerance, signed.
  localparam int unsigned THR_W = 21;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [0:0] REG_ANT_COUNT  = 1'b0;
  localparam logic [0:0] REG_SHADOW_TOL = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [ANT_IDX_W-1:0]      antenna_index;
    logic signed [POS_W-1:0]   pos_u;
    logic signed [POS_W-1:0]   pos_v;
    logic signed [POS_W-1:0]   pos_w;
    logic [DIAM_W-1:0]         dish_diameter;
    logic [ANT_IDX_W-1:0]      first_antenna;
    logic [ANT_IDX_W-1:0]      second_antenna;
  } in_item_t;

  typedef struct packed {
    logic row_flag;
    logic is_query_answer;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  pos_v;
    logic [POS_W-1:0]  pos_w;
    logic [DIAM_W-1:0] diam;
  } ant_entry_t;

  localparam int unsigned ENTRY_W = $bits(ant_entry_t);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RDA   = 5'b00010,
    ST_LDA   = 5'b00100,
    ST_WALKB = 5'b01000,
    ST_DRAIN = 5'b10000
  } ash_state_e;

  typedef struct packed {
    logic ram_we;       // store the accepted load
    logic res_load;     // load acknowledge into the output register
    logic res_query;    // answer from the incoming query fields
    logic res_walk;     // answer from the latched query after a walk
    logic latch_query;
    logic clear_mask;
    logic a_init;
    logic rd_a;         // read entry a
    logic latch_a;      // capture entry a from the RAM
    logic rd_b_first;   // read entry a+1
    logic rd_b_next;    // read entry b+1
    logic push;         // pair (a, b) enters the test pipeline
    logic a_inc;
  } ash_cmd_t;

  typedef struct packed {
    logic op_query;
    logic a_last;
    logic b_last;
    logic pipe_empty;
  } ash_stat_t;

endpackage

// ===== sv/antenna_shadow_flagger.sv =====
// ----------------------------------------------------------------------------
// antenna_shadow_flagger: shadow flags for antenna pairs
// Loads antenna positions and diameters, rebuilds the shadow set on demand
// and answers row queries.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the in_valid_i/in_ready_o channel. A load (op 0)
// stores one antenna and marks the shadow set stale; a query (op 1) asks
// whether either antenna of a row is shadowed. Every transaction in gives
// exactly one transaction out on out_valid_o/out_ready_i, in order.
// A load and a query on a fresh shadow set need no walk; the answer
// sits in the output register the cycle after acceptance.
// The first query after a load walks all pairs a<b of the first
// antenna_count antennas through one read port of the antenna RAM. The walk
// reads one antenna per cycle, so that read port sets its length. The block
// takes one item at a time. While a result waits for out_ready_i the input
// stays blocked; a result taken in the same cycle frees it. Reset clears
// the shadow set and marks it stale; antenna entries are undefined until
// loaded. Registers (APB, offset 0: antenna_count, offset 4:
// shadow_tolerance) are for the user to write only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module antenna_shadow_flagger
  import ash_pkg::*;
#(
  parameter int unsigned MAX_ANTENNAS = MAX_ANTENNAS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COUNT_W-1:0]      count_q;
  logic signed [TOL_W-1:0] tol_q;
  logic                    reg_wr;
  logic [0:0]              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tol_q   <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_ANT_COUNT:  count_q <= pwdata[COUNT_W-1:0];
        REG_SHADOW_TOL: tol_q   <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANT_COUNT:  prdata = {{(PDATA_W-COUNT_W){1'b0}}, count_q};
      REG_SHADOW_TOL: prdata = {{(PDATA_W-TOL_W){tol_q[TOL_W-1]}}, tol_q};
      default:        prdata = '0;
    endcase
  end

  ash_cmd_t  cmd;
  ash_stat_t stat;

  ash_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ash_dp #(
    .MaxAntennas (MAX_ANTENNAS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_count_i (count_q),
    .cfg_tol_i   (tol_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/ash_ram.sv =====
// ----------------------------------------------------------------------------
// ash_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ash_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ash_ctrl.sv =====
// ----------------------------------------------------------------------------
// ash_ctrl: controller of the antenna shadow flagger
// Handles the input and output handshakes, the stale flag and the sequence
// of the pair walk.
// ----------------------------------------------------------------------------
module ash_ctrl
  import ash_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ash_stat_t stat_i,
  output ash_cmd_t  cmd_o
);

  ash_state_e state_q, state_d;
  logic       stale_q, stale_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    stale_d     = stale_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.op_query == OP_LOAD) begin
            cmd_o.ram_we   = 1'b1;
            cmd_o.res_load = 1'b1;
            stale_d        = 1'b1;
            out_valid_d    = 1'b1;
          end else if (stale_q) begin
            cmd_o.latch_query = 1'b1;
            cmd_o.clear_mask  = 1'b1;
            cmd_o.a_init      = 1'b1;
            state_d           = ST_RDA;
          end else begin
            cmd_o.res_query = 1'b1;
            out_valid_d     = 1'b1;
          end
        end
      end
      ST_RDA: begin
        if (stat_i.a_last) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = ST_LDA;
        end
      end
      ST_LDA: begin
        cmd_o.latch_a    = 1'b1;
        cmd_o.rd_b_first = 1'b1;
        state_d          = ST_WALKB;
      end
      ST_WALKB: begin
        cmd_o.push = 1'b1;
        if (stat_i.b_last) begin
          cmd_o.a_inc = 1'b1;
          state_d     = ST_RDA;
        end else begin
          cmd_o.rd_b_next = 1'b1;
        end
      end
      ST_DRAIN: begin
        // The mask is final once the last pair has left the pipeline.
        if (stat_i.pipe_empty) begin
          cmd_o.res_walk = 1'b1;
          out_valid_d    = 1'b1;
          stale_d        = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/ash_dp.sv =====
// ----------------------------------------------------------------------------
// ash_dp: datapath of the antenna shadow flagger
// Antenna RAM, pair counters, a pipelined pair test (stage 1, stage 2,
// final compare) and the shadow mask.
module ash_dp
  import ash_pkg::*;
#(
  parameter int unsigned MaxAntennas = MAX_ANTENNAS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  in_item_t                in_item_i,
  input  logic [COUNT_W-1:0]      cfg_count_i,
  input  logic signed [TOL_W-1:0] cfg_tol_i,
  input  ash_cmd_t                cmd_i,
  output ash_stat_t               stat_o,
  output out_item_t               out_item_o
);

  localparam int unsigned AW = (MaxAntennas > 1) ? $clog2(MaxAntennas) : 1;
  localparam int unsigned CW = $clog2(MaxAntennas + 1);

  // Effective antenna count and pair counters.
  logic [CW-1:0] n_eff;
  logic [CW-1:0] a_q, b_q;
  logic [CW-1:0] a_nxt, b_nxt;

  assign n_eff = (32'(cfg_count_i) > MaxAntennas) ? CW'(MaxAntennas) : CW'(cfg_count_i);
  assign a_nxt = a_q + CW'(1);
  assign b_nxt = b_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      if (cmd_i.a_init) begin
        a_q <= '0;
      end else if (cmd_i.a_inc) begin
        a_q <= a_nxt;
      end
      if (cmd_i.rd_b_first) begin
        b_q <= a_nxt;
      end else if (cmd_i.rd_b_next) begin
        b_q <= b_nxt;
      end
    end
  end

  // Antenna RAM: writes come from loads, reads from the walk.
  ant_entry_t          wr_entry;
  logic [ENTRY_W-1:0]  rd_raw;
  ant_entry_t          rd_entry;
  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;

  assign wr_entry = '{pos_u: in_item_i.pos_u, pos_v: in_item_i.pos_v,
                      pos_w: in_item_i.pos_w, diam: in_item_i.dish_diameter};
  assign ram_we   = cmd_i.ram_we && (32'(in_item_i.antenna_index) < MaxAntennas);
  assign ram_re   = cmd_i.rd_a || cmd_i.rd_b_first || cmd_i.rd_b_next;

  always_comb begin
    ram_raddr = AW'(b_nxt);
    if (cmd_i.rd_a) begin
      ram_raddr = AW'(a_q);
    end else if (cmd_i.rd_b_first) begin
      ram_raddr = AW'(a_nxt);
    end
  end

  ash_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MaxAntennas)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_item_i.antenna_index)),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_raw)
  );

  assign rd_entry = ant_entry_t'(rd_raw);

  ant_entry_t ent_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      ent_a_q <= rd_entry;
    end
  end

  // Stage 1: differences, magnitudes and the threshold.
  logic [POS_W:0]  du_w, dv_w, dw_w;
  logic [POS_W:0]  du_m, dv_m;
  logic [THR_W-1:0] thr_w;
  logic            thr_pos;

  assign du_w = {rd_entry.pos_u[POS_W-1], rd_entry.pos_u}
              - {ent_a_q.pos_u[POS_W-1], ent_a_q.pos_u};
  assign dv_w = {rd_entry.pos_v[POS_W-1], rd_entry.pos_v}
              - {ent_a_q.pos_v[POS_W-1], ent_a_q.pos_v};
  assign dw_w = {rd_entry.pos_w[POS_W-1], rd_entry.pos_w}
              - {ent_a_q.pos_w[POS_W-1], ent_a_q.pos_w};
  assign du_m = du_w[POS_W] ? (~du_w + (POS_W+1)'(1)) : du_w;
  assign dv_m = dv_w[POS_W] ? (~dv_w + (POS_W+1)'(1)) : dv_w;

  // Twice the tolerance is the tolerance shifted left by one.
  assign thr_w = {{(THR_W-DIAM_W){1'b0}}, rd_entry.diam}
               + {{(THR_W-DIAM_W){1'b0}}, ent_a_q.diam}
               - {{(THR_W-TOL_W-1){cfg_tol_i[TOL_W-1]}}, cfg_tol_i, 1'b0};
  assign thr_pos = !thr_w[THR_W-1] && (|thr_w);

  logic              s1_v_q;
  logic [MAG_W-1:0]  s1_du_q, s1_dv_q;
  logic [THR_W-2:0]  s1_thr_q;
  logic              s1_ok_q;
  logic [AW-1:0]     s1_tgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      s1_du_q  <= du_m[MAG_W-1:0];
      s1_dv_q  <= dv_m[MAG_W-1:0];
      s1_thr_q <= thr_w[THR_W-2:0];
      s1_ok_q  <= thr_pos && !(|du_m[POS_W:MAG_W]) && !(|dv_m[POS_W:MAG_W]);
      s1_tgt_q <= dw_w[POS_W] ? AW'(a_q) : AW'(b_q);
    end
  end

  // Stage 2: squares.
  logic                    s2_v_q;
  logic [2*MAG_W-1:0]      s2_du2_q, s2_dv2_q;
  logic [2*(THR_W-1)-1:0]  s2_thr2_q;
  logic                    s2_ok_q;
  logic [AW-1:0]           s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_du2_q  <= s1_du_q * s1_du_q;
      s2_dv2_q  <= s1_dv_q * s1_dv_q;
      s2_thr2_q <= s1_thr_q * s1_thr_q;
      s2_ok_q   <= s1_ok_q;
      s2_tgt_q  <= s1_tgt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.push;
      s2_v_q <= s1_v_q;
    end
  end

  // Final compare: 4*(du^2 + dv^2) < T^2.
  logic [2*MAG_W:0]   dist_sum;
  logic [2*MAG_W+2:0] dist_x4;
  logic               pair_close;

  assign dist_sum   = {1'b0, s2_du2_q} + {1'b0, s2_dv2_q};
  assign dist_x4    = {dist_sum, 2'b00};
  assign pair_close = s2_v_q && s2_ok_q
                   && (dist_x4 < (2*MAG_W+3)'(s2_thr2_q));

  logic [MaxAntennas-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.clear_mask) begin
      mask_q <= '0;
    end else if (pair_close) begin
      mask_q[s2_tgt_q] <= 1'b1;
    end
  end

  // Query side.
  logic [ANT_IDX_W-1:0] q1_q, q2_q;
  logic [ANT_IDX_W-1:0] q1_sel, q2_sel;
  logic                 hit1, hit2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_query) begin
      q1_q <= in_item_i.first_antenna;
      q2_q <= in_item_i.second_antenna;
    end
  end

  assign q1_sel = cmd_i.res_walk ? q1_q : in_item_i.first_antenna;
  assign q2_sel = cmd_i.res_walk ? q2_q : in_item_i.second_antenna;
  assign hit1   = (32'(q1_sel) < MaxAntennas) && mask_q[AW'(q1_sel)];
  assign hit2   = (32'(q2_sel) < MaxAntennas) && mask_q[AW'(q2_sel)];

  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q <= '{row_flag: 1'b0, is_query_answer: 1'b0};
    end else if (cmd_i.res_query || cmd_i.res_walk) begin
      out_q <= '{row_flag: hit1 || hit2, is_query_answer: 1'b1};
    end
  end

  assign out_item_o = out_q;

  assign stat_o = '{op_query:   in_item_i.op,
                    a_last:     (a_nxt >= n_eff),
                    b_last:     (b_nxt >= n_eff),
                    pipe_empty: !s1_v_q && !s2_v_q};

endmodule

// ===== sv/ash_checker.sv =====
// ----------------------------------------------------------------------------
// ash_checker: port-level checks for the antenna shadow flagger
// Watches the item channels and flags handshake and ordering slips.
// ----------------------------------------------------------------------------
module ash_checker
  import ash_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A waiting result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output dropped or changed while stalled");

  // A load is acknowledged in the next cycle with a cleared flag.
  a_load_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op == OP_LOAD)
    |=> out_valid_o && !out_item_o.is_query_answer && !out_item_o.row_flag)
    else $error("load not acknowledged");

  // No input is taken while a result is stalled.
  a_no_overtake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // A transaction in is followed directly by its answer or by a blocked input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("second item taken before answer");

endmodule

bind antenna_shadow_flagger ash_checker u_ash_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/antenna_shadow_flagger_tb.sv =====
// ----------------------------------------------------------------------------
// antenna_shadow_flagger_tb: self-checking bench for the antenna shadow flagger
// Loads antennas and queries rows over valid/ready with random gaps on both
// sides. A scoreboard keeps its own copy of the antenna table and rebuilds
// the shadow set on the first query after a load to predict each answer.
// The antenna count and tolerance are changed between phases over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module antenna_shadow_flagger_tb
  import ash_pkg::*;
();

  localparam int STALL_LIMIT = 20000;
  localparam int ANT_DEPTH   = MAX_ANTENNAS_DEF;
  localparam longint MAG_LIMIT = longint'(1) << MAG_W;

  class shadow_scoreboard;
    bit [COUNT_W-1:0]      count_reg;
    bit signed [TOL_W-1:0] tol_reg;
    longint                u_mem [ANT_DEPTH];
    longint                v_mem [ANT_DEPTH];
    longint                w_mem [ANT_DEPTH];
    longint                d_mem [ANT_DEPTH];
    bit                    shadowed [ANT_DEPTH];
    bit                    stale;
    out_item_t             expected_answers [$];
    int                    mismatches;
    int                    loads_seen;
    int                    queries_seen;
    int                    flags_seen;
    int                    rebuilds;

    function new();
      count_reg = '0;
      tol_reg   = '0;
      stale     = 1'b1;
      foreach (shadowed[i]) begin
        shadowed[i] = 1'b0;
        u_mem[i] = 0;
        v_mem[i] = 0;
        w_mem[i] = 0;
        d_mem[i] = 0;
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function void write_reg(logic [0:0] reg_idx, int value);
      if (reg_idx == REG_ANT_COUNT) begin
        count_reg = value[COUNT_W-1:0];
      end else begin
        tol_reg = value[TOL_W-1:0];
      end
    endfunction

    function void flag_error(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    // Exact squared form of "distance below mean diameter minus tolerance".
    function bit pair_shadows(int a, int b);
      longint thr;
      longint du;
      longint dv;
      thr = d_mem[a] + d_mem[b] - 2 * longint'(tol_reg);
      du = u_mem[b] - u_mem[a];
      dv = v_mem[b] - v_mem[a];
      if (du < 0) du = -du;
      if (dv < 0) dv = -dv;
      if (thr <= 0) return 1'b0;
      if (du >= MAG_LIMIT || dv >= MAG_LIMIT) return 1'b0;
      return (4 * (du * du + dv * dv)) < (thr * thr);
    endfunction

    function void rebuild_shadow_set();
      int n;
      n = (count_reg > ANT_DEPTH) ? ANT_DEPTH : int'(count_reg);
      foreach (shadowed[i]) shadowed[i] = 1'b0;
      for (int a = 0; a < n; a++) begin
        for (int b = a + 1; b < n; b++) begin
          if (pair_shadows(a, b)) begin
            if (w_mem[b] - w_mem[a] < 0) shadowed[a] = 1'b1;
            else shadowed[b] = 1'b1;
          end
        end
      end
      stale = 1'b0;
      rebuilds++;
    endfunction

    function void note_item(in_item_t it);
      out_item_t e;
      if (it.op == OP_LOAD) begin
        u_mem[it.antenna_index] = longint'(it.pos_u);
        v_mem[it.antenna_index] = longint'(it.pos_v);
        w_mem[it.antenna_index] = longint'(it.pos_w);
        d_mem[it.antenna_index] = longint'({1'b0, it.dish_diameter});
        stale = 1'b1;
        e.row_flag = 1'b0;
        e.is_query_answer = 1'b0;
        loads_seen++;
      end else begin
        if (stale) rebuild_shadow_set();
        e.row_flag = shadowed[it.first_antenna] | shadowed[it.second_antenna];
        e.is_query_answer = 1'b1;
        queries_seen++;
        if (e.row_flag) flags_seen++;
      end
      expected_answers = {expected_answers, e};
    endfunction

    function void check_answer(out_item_t got);
      out_item_t e;
      if (expected_answers.size() == 0) begin
        flag_error($sformatf("result with nothing expected (flag %0b, answer %0b)",
                             got.row_flag, got.is_query_answer));
        return;
      end
      e = expected_answers.pop_front();
      if (got.row_flag !== e.row_flag) begin
        flag_error($sformatf("row_flag expected %0b, got %0b", e.row_flag, got.row_flag));
      end
      if (got.is_query_answer !== e.is_query_answer) begin
        flag_error($sformatf("is_query_answer expected %0b, got %0b",
                             e.is_query_answer, got.is_query_answer));
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  shadow_scoreboard sb;
  bit               steady_flow = 1'b0;
  bit               loaded [ANT_DEPTH];
  int               stall_cycles = 0;

  antenna_shadow_flagger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // Both channels are sampled before any update of this edge takes effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_answer(out_item_o);
      if (in_valid_i && in_ready_o) sb.note_item(in_item_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("antenna_shadow_flagger_tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic apb_write(input logic [0:0] reg_idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(reg_idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_item(input in_item_t it);
    if (!steady_flow) begin
      while ($urandom_range(99) < 13) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // The first edge lets the monitor note the transaction just accepted.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t load_item(int idx, int u, int v, int w, int diam);
    in_item_t it;
    it = '0;
    it.op            = OP_LOAD;
    it.antenna_index = idx[ANT_IDX_W-1:0];
    it.pos_u         = u;
    it.pos_v         = v;
    it.pos_w         = w;
    it.dish_diameter = diam[DIAM_W-1:0];
    return it;
  endfunction

  function automatic in_item_t query_item(int a, int b);
    in_item_t it;
    it = '0;
    it.op             = OP_QUERY;
    it.first_antenna  = a[ANT_IDX_W-1:0];
    it.second_antenna = b[ANT_IDX_W-1:0];
    return it;
  endfunction

  // Positions cluster around a center so that pairs often come close enough
  // to shadow; one load in ten is spread over the whole range.
  function automatic in_item_t random_load(int idx, int cu, int cv);
    in_item_t it;
    int       diam;
    case ($urandom_range(9))
      0:       diam = 0;
      1:       diam = (1 << DIAM_W) - 1;
      default: diam = $urandom_range((1 << DIAM_W) - 1);
    endcase
    if ($urandom_range(9) == 0) begin
      it = load_item(idx, $urandom, $urandom, $urandom, diam);
    end else begin
      it = load_item(idx, cu + int'($urandom_range(524288)) - 262144,
                     cv + int'($urandom_range(524288)) - 262144,
                     int'($urandom_range(2097152)) - 1048576, diam);
    end
    it.first_antenna  = ANT_IDX_W'($urandom);
    it.second_antenna = ANT_IDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_query(int eff);
    in_item_t it;
    it = query_item($urandom_range(63), $urandom_range(63));
    if (eff > 0 && $urandom_range(9) < 7) begin
      it.first_antenna = ANT_IDX_W'($urandom_range(eff - 1));
    end
    if (eff > 0 && $urandom_range(9) < 7) begin
      it.second_antenna = ANT_IDX_W'($urandom_range(eff - 1));
    end
    it.antenna_index = ANT_IDX_W'($urandom);
    it.pos_u         = $urandom;
    it.pos_v         = $urandom;
    it.pos_w         = $urandom;
    it.dish_diameter = DIAM_W'($urandom_range((1 << DIAM_W) - 1));
    return it;
  endfunction

  task automatic run_directed();
    apb_write(REG_ANT_COUNT, 8);
    apb_write(REG_SHADOW_TOL, 0);
    // Antennas 0 and 1 sit exactly at the threshold, which is not a shadow.
    send_item(load_item(0, 0, 0, 0, 2048));
    send_item(load_item(1, 2048, 0, 5, 2048));
    // Just inside the threshold with w behind: the first antenna is shadowed.
    send_item(load_item(2, 0, 2047, -1, 2048));
    // Equal w shadows the second antenna of the pair.
    send_item(load_item(3, -100, 100, 0, 2048));
    // Opposite corners of the coordinate range, far apart.
    send_item(load_item(4, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 262143));
    send_item(load_item(5, 32'h80000000, 32'h7fffffff, 32'h80000000, 262143));
    send_item(load_item(6, 1000000, 0, 0, 262143));
    send_item(load_item(7, 1200000, 0, -7, 262143));
    for (int i = 0; i < 8; i++) loaded[i] = 1'b1;
    send_item(query_item(0, 0));
    send_item(query_item(1, 1));
    send_item(query_item(2, 3));
    send_item(query_item(3, 1));
    send_item(query_item(4, 5));
    send_item(query_item(6, 7));
    send_item(query_item(7, 6));
    // Antennas beyond the count are never shadowed.
    send_item(query_item(8, 63));
    send_item(query_item(63, 0));
    send_item(load_item(1, 2047, 0, 5, 2048));
    send_item(query_item(1, 62));
    send_item(query_item(5, 4));
    drain_answers();
    // A new tolerance alone leaves the shadow set as it was.
    apb_write(REG_SHADOW_TOL, -262144);
    send_item(query_item(4, 5));
    send_item(query_item(0, 7));
    send_item(load_item(5, 1100000, 1, 3, 0));
    send_item(query_item(4, 5));
    drain_answers();
  endtask

  task automatic run_phase(input int count, input int tol, input int n_items,
                           input bit steady, input bit mid_pause);
    int eff;
    int cu;
    int cv;
    int idx;
    eff = (count > ANT_DEPTH) ? ANT_DEPTH : count;
    cu  = $urandom;
    cv  = $urandom;
    steady_flow <= steady;
    apb_write(REG_ANT_COUNT, count);
    apb_write(REG_SHADOW_TOL, tol);
    // Every antenna that the walk reads must hold a loaded entry.
    for (int i = 0; i < eff; i++) begin
      if (!loaded[i]) begin
        send_item(random_load(i, cu, cv));
        loaded[i] = 1'b1;
      end
    end
    for (int k = 0; k < n_items; k++) begin
      if (mid_pause && k == n_items / 2) drain_answers();
      if ($urandom_range(99) < 40) begin
        idx = (eff > 0 && $urandom_range(9) < 8) ? $urandom_range(eff - 1)
                                                 : $urandom_range(63);
        send_item(random_load(idx, cu, cv));
        loaded[idx] = 1'b1;
      end else begin
        send_item(random_query(eff));
      end
    end
    drain_answers();
  endtask

  initial begin
    sb = new();
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(0, 262143, 20, 1'b0, 1'b0);
    run_phase(1, -262144, 20, 1'b0, 1'b0);
    run_phase(2, -262144, 30, 1'b0, 1'b0);
    run_phase(5, int'($urandom_range(524287)) - 262144, 60, 1'b0, 1'b1);
    run_phase(16, int'($urandom_range(300000)) - 150000, 80, 1'b1, 1'b0);
    run_phase(64, 0, 60, 1'b0, 1'b0);
    run_phase(127, -262144, 30, 1'b0, 1'b0);
    run_phase(12, 262143, 30, 1'b0, 1'b0);
    run_phase(6, -int'($urandom_range(262144)), 50, 1'b0, 1'b1);

    repeat (10) @(posedge clk_i);
    $display("antenna_shadow_flagger_tb: %0d loads, %0d row queries (%0d flagged), %0d walks",
             sb.loads_seen, sb.queries_seen, sb.flags_seen, sb.rebuilds);
    $display("antenna_shadow_flagger_tb: counts 0 to 127, tolerance extremes, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("antenna_shadow_flagger_tb: done, clean");
    end else begin
      $display("antenna_shadow_flagger_tb: done, errors");
    end
    $finish;
  end

endmodule
